### hw/rtl/rlaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlaf_pkg
// Shared types, constants and tables for the red line angle fit block.
// ----------------------------------------------------------------------------
package rlaf_pkg;

    // Default build values.
    localparam int COORD_BITS_DEF      = 10;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // Port widths fixed by the interface.
    localparam int CFG_W   = 11;
    localparam int CFG_IDX = 2;
    localparam int PIX_W   = 8;
    localparam int ANG_W   = 16;
    localparam int STAT_W  = 2;
    localparam int PC_W    = 21;

    localparam logic [PC_W-1:0] PC_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX-1:0] CFG_BLUE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX-1:0] CFG_RED_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX-1:0] CFG_FRAME_WIDTH   = 2'd2;

    // Configuration reset values.
    localparam logic [PIX_W-1:0] BLUE_LIMIT_RST    = 8'd104;
    localparam logic [PIX_W-1:0] RED_THRESHOLD_RST = 8'd150;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST   = 11'd640;

    // Fit status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_VERT = 2'd2;

    // CORDIC settings: angle table in degrees, Q16.
    localparam int CORDIC_STEPS = 23;
    localparam int STEP_W       = 5;
    localparam int ANG_Q        = 16;
    localparam int ATAN_W       = 25;
    localparam int NORM_BITS    = 30;
    localparam int XW           = 34;
    localparam int DEG_FEW      = 45;
    localparam int DEG_VERT     = 90;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAIN,
        S_MUL_LD,
        S_MUL,
        S_CHECK,
        S_NORM,
        S_CORDIC,
        S_ROUND,
        S_OUT
    } t_state;

    // Which partial product the shared shift-add unit is working on.
    typedef enum logic [1:0] {
        PH_NXY,
        PH_SXY,
        PH_NXX,
        PH_SXX
    } t_phase;

    function automatic logic signed [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic signed [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat16(input logic signed [31:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/red_line_angle_fit.sv
`timescale 1ns / 1ps
// Pixels are taken one per cycle while the block is idle; the sums are updated in the following cycle.
// At the end of a frame the block stalls while it computes the fit with the bit-serial shift-add
// multiplier, the one-bit normalizer and the 23-step CORDIC (the last two only when needed).
// Once the result sits in the output register the next frame starts. Synchronous active-low reset
// clears the counters, sums and state and restores the register defaults.
// ----------------------------------------------------------------------------
// red_line_angle_fit
// Accumulates the least-squares sums of the active red pixels of a raster frame
// and reports the fitted line angle in degrees at the end of each frame.
// ----------------------------------------------------------------------------
module red_line_angle_fit #(
    parameter int COORD_BITS      = rlaf_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = rlaf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rlaf_pkg::CFG_IDX-1:0]        i_cfg_idx,
    input  logic [rlaf_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rlaf_pkg::PIX_W-1:0]          i_blue,
    input  logic [rlaf_pkg::PIX_W-1:0]          i_red,
    input  logic                                i_last_of_frame,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rlaf_pkg::ANG_W-1:0]   o_angle_deg_q8,
    output logic [rlaf_pkg::STAT_W-1:0]         o_fit_status,
    output logic [rlaf_pkg::PC_W-1:0]           o_point_count
);
    import rlaf_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = ANGLE_FRAC_BITS;
    localparam int CNT_W = 2 * C + 1;
    localparam int S1_W  = 3 * C + 1;
    localparam int S2_W  = 4 * C + 1;
    localparam int PW    = 6 * C + 2;
    localparam int ACC_W = PW + 1;
    localparam int MAG_W = (PW > NORM_BITS + 1) ? PW : NORM_BITS + 1;
    localparam int BC_W  = $clog2(S1_W);

    localparam logic signed [31:0] ANG90      = 32'sd90 <<< ANG_Q;
    localparam logic signed [31:0] ROUND_HALF = 32'sd1 <<< (ANG_Q - F - 1);
    localparam logic signed [ANG_W-1:0] FEW_ANGLE  = sat16(-(32'(DEG_FEW) <<< F));
    localparam logic signed [ANG_W-1:0] VERT_ANGLE = sat16(32'(DEG_VERT) <<< F);

    // Configuration.
    logic [PIX_W-1:0] r_cfg_blue, r_cfg_red;
    logic [CFG_W-1:0] r_cfg_fw;

    // Raster position and frame sums.
    logic [C-1:0]     r_col, n_col, r_row, n_row;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [S1_W-1:0]  r_sx, n_sx, r_sy, n_sy;
    logic [S2_W-1:0]  r_sxy, n_sxy, r_sxx, n_sxx;

    // Pixel pipeline stage between the products and the sums.
    logic             r_p_vld, n_p_vld;
    logic             r_p_act, n_p_act;
    logic [C-1:0]     r_p_x, n_p_x, r_p_y, n_p_y;
    logic [2*C-1:0]   r_p_xy, n_p_xy, r_p_xx, n_p_xx;

    // Sequencer and shared datapath.
    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [BC_W-1:0]  r_bitcnt, n_bitcnt;
    logic [STEP_W-1:0] r_step, n_step;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [PW-1:0]    r_mcand, n_mcand;
    logic [S1_W-1:0]  r_mplier, n_mplier;
    logic [MAG_W-1:0] r_nm, n_nm, r_dm, n_dm;
    logic             r_nneg, n_nneg, r_dneg, n_dneg;
    logic signed [XW-1:0]     r_x, n_x, r_y, n_y;
    logic signed [ATAN_W-1:0] r_z, n_z;
    logic signed [ANG_W-1:0]  r_res_angle, n_res_angle;
    logic [STAT_W-1:0]        r_res_status, n_res_status;

    // Output register.
    logic                     r_out_valid, n_out_valid;
    logic signed [ANG_W-1:0]  r_o_angle, n_o_angle;
    logic [STAT_W-1:0]        r_o_status, n_o_status;
    logic [PC_W-1:0]          r_o_count, n_o_count;

    logic                     in_acc;
    logic                     pix_active;
    logic                     col_wrap;
    logic                     acc_neg;
    logic [ACC_W-1:0]         acc_neg_val;
    logic [PW-1:0]            acc_mag;
    logic signed [ACC_W-1:0]  addend;
    logic                     phase_sub;
    logic signed [XW-1:0]     cx_dx, cx_dy;
    logic signed [31:0]       zc, zr;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && (r_state == S_IDLE);
    assign pix_active     = (i_blue <= r_cfg_blue) && (i_red > r_cfg_red);
    // A frame width of zero behaves as one, and widths past the coordinate range wrap at its end.
    assign col_wrap       = ((32'(r_col) + 32'd1) >= 32'(r_cfg_fw)) || (r_col == '1);

    assign acc_neg        = r_acc[ACC_W-1];
    assign acc_neg_val    = -r_acc;
    assign acc_mag        = acc_neg ? acc_neg_val[PW-1:0] : r_acc[PW-1:0];
    assign phase_sub      = (r_phase == PH_SXY) || (r_phase == PH_SXX);
    assign addend         = phase_sub ? -$signed(ACC_W'(r_mcand)) : $signed(ACC_W'(r_mcand));
    assign cx_dx          = r_y >>> r_step;
    assign cx_dy          = r_x >>> r_step;

    assign o_out_valid    = r_out_valid;
    assign o_angle_deg_q8 = r_o_angle;
    assign o_fit_status   = r_o_status;
    assign o_point_count  = r_o_count;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_bitcnt     = r_bitcnt;
        n_step       = r_step;
        n_acc        = r_acc;
        n_mcand      = r_mcand;
        n_mplier     = r_mplier;
        n_nm         = r_nm;
        n_dm         = r_dm;
        n_nneg       = r_nneg;
        n_dneg       = r_dneg;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_res_angle  = r_res_angle;
        n_res_status = r_res_status;
        n_o_angle    = r_o_angle;
        n_o_status   = r_o_status;
        n_o_count    = r_o_count;
        n_col        = r_col;
        n_row        = r_row;
        n_cnt        = r_cnt;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_sxy        = r_sxy;
        n_sxx        = r_sxx;
        n_p_vld      = 1'b0;
        n_p_act      = r_p_act;
        n_p_x        = r_p_x;
        n_p_y        = r_p_y;
        n_p_xy       = r_p_xy;
        n_p_xx       = r_p_xx;
        zc           = '0;
        zr           = '0;

        n_out_valid = r_out_valid && i_out_stall;

        // Sums take the pixel registered in the previous cycle.
        if (r_p_vld && r_p_act) begin
            n_cnt = r_cnt + CNT_W'(1);
            n_sx  = r_sx + S1_W'(r_p_x);
            n_sy  = r_sy + S1_W'(r_p_y);
            n_sxy = r_sxy + S2_W'(r_p_xy);
            n_sxx = r_sxx + S2_W'(r_p_xx);
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_p_vld = 1'b1;
                    n_p_act = pix_active;
                    n_p_x   = r_col;
                    n_p_y   = r_row;
                    n_p_xy  = r_col * r_row;
                    n_p_xx  = r_col * r_col;
                    if (i_last_of_frame) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_state = S_DRAIN;
                    end else if (col_wrap) begin
                        n_col = '0;
                        n_row = r_row + C'(1);
                    end else begin
                        n_col = r_col + C'(1);
                    end
                end
            end
            S_DRAIN: begin
                n_phase = PH_NXY;
                n_state = S_MUL_LD;
            end
            S_MUL_LD: begin
                n_bitcnt = '0;
                case (r_phase)
                    PH_NXY: begin
                        n_acc    = '0;
                        n_mplier = S1_W'(r_cnt);
                        n_mcand  = PW'(r_sxy);
                    end
                    PH_SXY: begin
                        n_mplier = r_sx;
                        n_mcand  = PW'(r_sy);
                    end
                    PH_NXX: begin
                        // The numerator is complete; keep its sign and magnitude.
                        n_nneg   = acc_neg;
                        n_nm     = MAG_W'(acc_mag);
                        n_acc    = '0;
                        n_mplier = S1_W'(r_cnt);
                        n_mcand  = PW'(r_sxx);
                    end
                    PH_SXX: begin
                        n_mplier = r_sx;
                        n_mcand  = PW'(r_sx);
                    end
                    default: begin
                        n_mplier = '0;
                    end
                endcase
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + addend;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_bitcnt = r_bitcnt + BC_W'(1);
                if (r_bitcnt == BC_W'(S1_W - 1)) begin
                    case (r_phase)
                        PH_NXY:  begin n_phase = PH_SXY; n_state = S_MUL_LD; end
                        PH_SXY:  begin n_phase = PH_NXX; n_state = S_MUL_LD; end
                        PH_NXX:  begin n_phase = PH_SXX; n_state = S_MUL_LD; end
                        default: n_state = S_CHECK;
                    endcase
                end
            end
            S_CHECK: begin
                n_dneg       = acc_neg;
                n_dm         = MAG_W'(acc_mag);
                n_res_status = ST_OK;
                if (r_cnt < CNT_W'(2)) begin
                    n_res_angle  = FEW_ANGLE;
                    n_res_status = ST_FEW;
                    n_state      = S_OUT;
                end else if (acc_mag == '0) begin
                    n_res_angle  = VERT_ANGLE;
                    n_res_status = ST_VERT;
                    n_state      = S_OUT;
                end else if (r_nm == '0) begin
                    n_res_angle = '0;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // Shift both magnitudes together until each fits in the CORDIC range.
                if ((|r_nm[MAG_W-1:NORM_BITS]) || (|r_dm[MAG_W-1:NORM_BITS])) begin
                    n_nm = r_nm >> 1;
                    n_dm = r_dm >> 1;
                end else begin
                    n_x     = $signed(XW'(r_dm[NORM_BITS-1:0]));
                    n_y     = $signed(XW'(r_nm[NORM_BITS-1:0]));
                    n_z     = '0;
                    n_step  = '0;
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (!r_y[XW-1] && (r_y != '0)) begin
                    n_x = r_x + cx_dx;
                    n_y = r_y - cx_dy;
                    n_z = r_z + atan_entry(r_step);
                end else begin
                    n_x = r_x - cx_dx;
                    n_y = r_y + cx_dy;
                    n_z = r_z - atan_entry(r_step);
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                zc = 32'(r_z);
                if (zc < 32'sd0) begin
                    zc = 32'sd0;
                end else if (zc > ANG90) begin
                    zc = ANG90;
                end
                zr = (zc + ROUND_HALF) >>> (ANG_Q - F);
                if (r_nneg == r_dneg) begin
                    zr = -zr;
                end
                n_res_angle = sat16(zr);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_angle   = r_res_angle;
                    n_o_status  = r_res_status;
                    n_o_count   = (32'(r_cnt) > 32'(PC_MAX)) ? PC_MAX : PC_W'(r_cnt);
                    n_cnt       = '0;
                    n_sx        = '0;
                    n_sy        = '0;
                    n_sxy       = '0;
                    n_sxx       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_NXY;
            r_bitcnt    <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_p_vld     <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxy       <= '0;
            r_sxx       <= '0;
            r_cfg_blue  <= BLUE_LIMIT_RST;
            r_cfg_red   <= RED_THRESHOLD_RST;
            r_cfg_fw    <= FRAME_WIDTH_RST;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bitcnt    <= n_bitcnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_p_vld     <= n_p_vld;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_sxy       <= n_sxy;
            r_sxx       <= n_sxx;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLUE_LIMIT:    r_cfg_blue <= i_cfg_data[PIX_W-1:0];
                    CFG_RED_THRESHOLD: r_cfg_red  <= i_cfg_data[PIX_W-1:0];
                    CFG_FRAME_WIDTH:   r_cfg_fw   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_act      <= n_p_act;
        r_p_x        <= n_p_x;
        r_p_y        <= n_p_y;
        r_p_xy       <= n_p_xy;
        r_p_xx       <= n_p_xx;
        r_acc        <= n_acc;
        r_mcand      <= n_mcand;
        r_mplier     <= n_mplier;
        r_nm         <= n_nm;
        r_dm         <= n_dm;
        r_nneg       <= n_nneg;
        r_dneg       <= n_dneg;
        r_x          <= n_x;
        r_y          <= n_y;
        r_z          <= n_z;
        r_res_angle  <= n_res_angle;
        r_res_status <= n_res_status;
        r_o_angle    <= n_o_angle;
        r_o_status   <= n_o_status;
        r_o_count    <= n_o_count;
    end

`ifndef SYNTHESIS
    a_last_starts_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_of_frame) |=> (r_state == S_DRAIN))
        else $error("last beat of a frame did not start the fit");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result beat appeared outside the output state");

    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (32'(r_step) < CORDIC_STEPS))
        else $error("CORDIC step index out of range");

    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (32'(r_bitcnt) < S1_W))
        else $error("multiplier bit counter out of range");

    a_no_pixel_in_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> !($past(r_p_vld) && (r_state == S_MUL))
            || (r_state != S_MUL))
        else $error("pixel entered the sums while the fit was running");
`endif

endmodule
